@@ hw/rtl/hpr_pkg.sv @@
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared types and codes for the highest-priority ready select block.
// ----------------------------------------------------------------------------
package hpr_pkg;

  typedef struct packed {
    logic [7:0] id;
    logic [5:0] prio;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

endpackage

@@ hw/rtl/hpr_ram.sv @@
// ----------------------------------------------------------------------------
// hpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hpr_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/hpr_best.sv @@
// ----------------------------------------------------------------------------
// hpr_best
// Compare unit: keeps the running highest-priority entry of a scan.
// ----------------------------------------------------------------------------
module hpr_best
  import hpr_pkg::*;
#(
  parameter int unsigned IW = 4
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [IW-1:0] idx_i,
  input  entry_t        cand_i,
  output logic [IW-1:0] best_idx_o,
  output entry_t        best_o
);

  logic [IW-1:0] best_idx_q, best_idx_d;
  entry_t        best_q, best_d;
  logic          take;

  // strict greater keeps the earliest arrival among equal priorities
  assign take = (idx_i == '0) || (cand_i.prio > best_q.prio);

  always_comb begin
    best_idx_d = best_idx_q;
    best_d     = best_q;
    if (en_i && take) begin
      best_idx_d = idx_i;
      best_d     = cand_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
  end

  assign best_idx_o = best_idx_q;
  assign best_o     = best_q;

endmodule

@@ hw/rtl/highest_priority_ready_select_top.sv @@
// ----------------------------------------------------------------------------
// highest_priority_ready_select_top
// Ready queue in arrival order; pop removes the highest-priority entry.
// ----------------------------------------------------------------------------
// Insert, full insert and empty pop: result state, then registered output.
// Pop: one RAM read port and one compare unit walk the scan, then the same
// port compacts the entries above the best one.
// One transaction in flight; the next is taken while a result waits.
// Reset clears the entry count and idle id; entries are not cleared.
// ----------------------------------------------------------------------------
module highest_priority_ready_select_top
  import hpr_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] thread_id_i,
  input  logic [5:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] chosen_id_o,
  output logic [5:0] chosen_priority_o,
  output logic [4:0] occupancy_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_SETUP  = 7'b0001000,
    S_SHIFT  = 7'b0010000,
    S_FLUSH  = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rvalid_q, rvalid_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic [7:0]    idle_id_q;

  status_e       res_status_q, res_status_d;
  logic [7:0]    res_id_q, res_id_d;
  logic [5:0]    res_prio_q, res_prio_d;

  logic          out_valid_q, out_valid_d;
  status_e       out_status_q, out_status_d;
  logic [7:0]    out_id_q, out_id_d;
  logic [5:0]    out_prio_q, out_prio_d;
  logic [4:0]    out_occ_q, out_occ_d;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;
  entry_t        rdata;
  logic [EntryW-1:0] rdata_raw;

  logic          cmp_en;
  logic [IW-1:0] best_idx;
  entry_t        best;

  hpr_ram #(
    .WIDTH (EntryW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  assign cmp_en = rvalid_q && ((state_q == S_SCAN) || (state_q == S_DRAIN));

  hpr_best #(
    .IW (IW)
  ) u_best (
    .clk_i      (clk_i),
    .en_i       (cmp_en),
    .idx_i      (ridx_q),
    .cand_i     (rdata),
    .best_idx_o (best_idx),
    .best_o     (best)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    rvalid_d     = 1'b0;
    ridx_d       = ridx_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_prio_d   = res_prio_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_prio_d   = out_prio_q;
    out_occ_d    = out_occ_q;
    we           = 1'b0;
    waddr        = ridx_q - IW'(1);
    wdata        = rdata;
    raddr        = idx_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_id_d   = '0;
          res_prio_d = '0;
          if (opcode_i == OP_INSERT) begin
            state_d = S_RESULT;
            if (count_q == CW'(DEPTH)) begin
              res_status_d = ST_FULL;
            end else begin
              we           = 1'b1;
              waddr        = count_q[IW-1:0];
              wdata        = '{id: thread_id_i, prio: priority_req_i};
              count_d      = count_q + CW'(1);
              res_status_d = ST_INSERTED;
            end
          end else if (count_q == '0) begin
            state_d      = S_RESULT;
            res_status_d = ST_EMPTY;
            res_id_d     = idle_id_q;
          end else begin
            state_d = S_SCAN;
            idx_d   = '0;
          end
        end
      end
      S_SCAN: begin
        rvalid_d = 1'b1;
        ridx_d   = idx_q[IW-1:0];
        if (idx_q == count_q - CW'(1)) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_SETUP;
      end
      S_SETUP: begin
        idx_d   = CW'(best_idx) + CW'(1);
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        we = rvalid_q;
        if (idx_q < count_q) begin
          rvalid_d = 1'b1;
          ridx_d   = idx_q[IW-1:0];
          idx_d    = idx_q + CW'(1);
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        we           = rvalid_q;
        count_d      = count_q - CW'(1);
        res_status_d = ST_POPPED;
        res_id_d     = best.id;
        res_prio_d   = best.prio;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_prio_d   = res_prio_q;
          out_occ_d    = 5'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      idle_id_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        idle_id_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    ridx_q       <= ridx_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_prio_q   <= res_prio_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_prio_q   <= out_prio_d;
    out_occ_q    <= out_occ_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign chosen_id_o       = out_id_q;
  assign chosen_priority_o = out_prio_q;
  assign occupancy_o       = out_occ_q;

  // every accepted transaction takes the block out of idle in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted a transaction back to back");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(waddr) <= count_q))
    else $error("write beyond held entries");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(status_o) && $stable(occupancy_o))
    else $error("pending result overwritten");

endmodule
